>>> hdl/dcmh_pkg.sv
package dcmh_pkg;

  // fixed field widths of the channels
  localparam int CoeffW    = 16;
  localparam int PosW      = 6;
  localparam int ReadBinW  = 8;
  localparam int OutBinW   = 8;
  localparam int OutCountW = 32;
  localparam int ShiftW    = 4;

  // bin_shift value after reset
  localparam logic [ShiftW-1:0] ShiftReset = 4'd2;

  // function codes of an input word
  typedef enum logic {
    FUNC_ACC  = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

endpackage

>>> hdl/dcmh_if.sv
// coefficient / read request channel
interface dcmh_in_if;
  logic                                valid;
  logic                                ready;
  dcmh_pkg::func_t                     func;
  logic signed [dcmh_pkg::CoeffW-1:0]  coeff;
  logic [dcmh_pkg::PosW-1:0]           position;
  logic [dcmh_pkg::ReadBinW-1:0]       read_bin;

  modport source (output valid, func, coeff, position, read_bin, input ready);
  modport sink   (input valid, func, coeff, position, read_bin, output ready);
  modport mon    (input valid, ready, func, coeff, position, read_bin);
endinterface

// result channel
interface dcmh_out_if;
  logic                             valid;
  logic                             ready;
  logic [dcmh_pkg::OutBinW-1:0]     bin;
  logic [dcmh_pkg::OutCountW-1:0]   count;
  logic                             saturated;

  modport source (output valid, bin, count, saturated, input ready);
  modport sink   (input valid, bin, count, saturated, output ready);
  modport mon    (input valid, ready, bin, count, saturated);
endinterface

// bin_shift write channel
interface dcmh_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dcmh_pkg::ShiftW-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
  modport mon    (input valid, ready, data);
endinterface

>>> hdl/dcmh_ram.sv
module dcmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port (read returns old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/dct_coeff_magnitude_histogram.sv
// path: a word accepted is registered in stage 1 (ram read data) and then in the output register
// throughput: one word per cycle while the output is not stalled; counters sit in one ram,
//   read-modify-write over two stages with the last write forwarded to the following read
// reset: bin_shift returns to 2, then a clearing pass writes zero to all
//   POSITIONS*(MAX_BIN+1) counters, one a cycle (8256 counters at defaults), in ready low
module dct_coeff_magnitude_histogram #(
  parameter int MAX_BIN    = 128,
  parameter int POSITIONS  = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  dcmh_in_if.sink    in_if,
  dcmh_out_if.source out_if,
  dcmh_cfg_if.sink   cfg_if
);

  localparam int NumBins = MAX_BIN + 1;
  localparam int Cells   = POSITIONS * NumBins;
  localparam int AddrW   = $clog2(Cells);
  localparam int BinW    = $clog2(NumBins);
  localparam int BinXW   = (BinW > dcmh_pkg::OutBinW) ? BinW : dcmh_pkg::OutBinW;
  localparam int CntXW   = (COUNT_BITS > dcmh_pkg::OutCountW) ? COUNT_BITS
                                                              : dcmh_pkg::OutCountW;
  localparam logic [COUNT_BITS-1:0]  CntMax    = '1;
  localparam logic [dcmh_pkg::CoeffW-1:0] MaxBinC = dcmh_pkg::CoeffW'(MAX_BIN);
  localparam logic [AddrW-1:0]       LastAddr  = AddrW'(Cells - 1);

  // configuration
  logic [dcmh_pkg::ShiftW-1:0] shift_r;

  // clearing pass
  logic             clr_busy_r, clr_busy_nxt;
  logic [AddrW-1:0] clr_addr_r, clr_addr_nxt;

  // stage 1 (ram read data valid)
  logic                        s1_vld_r, s1_vld_nxt;
  logic                        s1_acc_r;
  logic                        s1_rd_ok_r;
  logic [AddrW-1:0]            s1_addr_r;
  logic [dcmh_pkg::OutBinW-1:0] s1_bin_r;

  // last write, forwarded into stage 1
  logic                  wr_vld_r, wr_vld_nxt;
  logic [AddrW-1:0]      wr_addr_r;
  logic [COUNT_BITS-1:0] wr_data_r;

  // output register
  logic                          out_vld_r, out_vld_nxt;
  logic [dcmh_pkg::OutBinW-1:0]  out_bin_r;
  logic [dcmh_pkg::OutCountW-1:0] out_count_r;
  logic                          out_sat_r;

  // stage 0 signals
  logic                         accept;
  logic                         out_free;
  logic                         s1_fire;
  logic [dcmh_pkg::CoeffW-1:0]  coeff_u;
  logic [dcmh_pkg::CoeffW-1:0]  mag;
  logic [dcmh_pkg::CoeffW-1:0]  shifted;
  logic [BinW-1:0]              acc_bin;
  logic [BinXW-1:0]             acc_bin_x;
  logic [BinXW-1:0]             rd_bin_x;
  logic [BinW-1:0]              sel_bin;
  logic                         pos_ok;
  logic                         rd_in_range;
  logic [AddrW-1:0]             rd_addr;
  logic [dcmh_pkg::OutBinW-1:0] s0_bin;

  // stage 1 signals
  logic [COUNT_BITS-1:0] ram_rd_data;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  cur_sat;
  logic [COUNT_BITS-1:0] res_cnt;
  logic                  res_sat;
  logic [CntXW-1:0]      res_cnt_x;

  // ram write port
  logic                  ram_we;
  logic [AddrW-1:0]      ram_wr_addr;
  logic [COUNT_BITS-1:0] ram_wr_data;

  // handshakes
  assign out_free    = !out_vld_r || out_if.ready;
  assign s1_fire     = s1_vld_r && out_free;
  assign in_if.ready = !clr_busy_r && (!s1_vld_r || out_free);
  assign accept      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  // magnitude, shift and clip to the top bin
  assign coeff_u = dcmh_pkg::CoeffW'(in_if.coeff);
  assign mag     = coeff_u[dcmh_pkg::CoeffW-1] ? (dcmh_pkg::CoeffW'(0) - coeff_u) : coeff_u;
  assign shifted = mag >> shift_r;
  assign acc_bin = (shifted > MaxBinC) ? BinW'(MAX_BIN) : BinW'(shifted);
  assign acc_bin_x = BinXW'(acc_bin);

  // range checks and counter address
  assign rd_bin_x    = BinXW'(in_if.read_bin);
  assign rd_in_range = rd_bin_x <= BinXW'(MAX_BIN);
  assign pos_ok      = 9'(in_if.position) < 9'(POSITIONS);
  assign sel_bin     = (in_if.func == dcmh_pkg::FUNC_READ) ? BinW'(rd_bin_x) : acc_bin;
  assign rd_addr     = AddrW'(32'(in_if.position) * 32'(NumBins) + 32'(sel_bin));
  assign s0_bin      = (in_if.func == dcmh_pkg::FUNC_READ) ? in_if.read_bin
                                                           : acc_bin_x[dcmh_pkg::OutBinW-1:0];

  // counter store
  dcmh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (Cells)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .re      (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // modify: forward the last write when it hit the same counter
  assign cur_cnt = (wr_vld_r && (wr_addr_r == s1_addr_r)) ? wr_data_r : ram_rd_data;
  assign cur_sat = cur_cnt == CntMax;
  assign new_cnt = cur_sat ? cur_cnt : cur_cnt + COUNT_BITS'(1);

  always_comb begin
    res_cnt = '0;
    res_sat = 1'b0;
    if (s1_acc_r) begin
      res_cnt = new_cnt;
      res_sat = cur_sat;
    end else if (s1_rd_ok_r) begin
      res_cnt = cur_cnt;
      res_sat = cur_sat;
    end
  end
  assign res_cnt_x = CntXW'(res_cnt);

  // write back, or zero fill while clearing
  assign ram_we      = clr_busy_r || (s1_fire && s1_acc_r);
  assign ram_wr_addr = clr_busy_r ? clr_addr_r : s1_addr_r;
  assign ram_wr_data = clr_busy_r ? '0 : new_cnt;

  // next state of control registers
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + AddrW'(1);
      if (clr_addr_r == LastAddr) begin
        clr_busy_nxt = 1'b0;
      end
    end

    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_vld_nxt = 1'b0;
    end

    wr_vld_nxt = wr_vld_r;
    if (clr_busy_r) begin
      wr_vld_nxt = 1'b0;
    end else if (s1_fire && s1_acc_r) begin
      wr_vld_nxt = 1'b1;
    end

    out_vld_nxt = out_vld_r;
    if (s1_fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r    <= dcmh_pkg::ShiftReset;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      s1_vld_r   <= 1'b0;
      wr_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        shift_r <= cfg_if.data;
      end
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      s1_vld_r   <= s1_vld_nxt;
      wr_vld_r   <= wr_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_acc_r   <= (in_if.func == dcmh_pkg::FUNC_ACC) && pos_ok;
      s1_rd_ok_r <= (in_if.func == dcmh_pkg::FUNC_READ) && pos_ok && rd_in_range;
      s1_addr_r  <= rd_addr;
      s1_bin_r   <= s0_bin;
    end
    if (s1_fire && s1_acc_r) begin
      wr_addr_r <= s1_addr_r;
      wr_data_r <= new_cnt;
    end
    if (s1_fire) begin
      out_bin_r   <= s1_bin_r;
      out_count_r <= res_cnt_x[dcmh_pkg::OutCountW-1:0];
      out_sat_r   <= res_sat;
    end
  end

  assign out_if.valid     = out_vld_r;
  assign out_if.bin       = out_bin_r;
  assign out_if.count     = out_count_r;
  assign out_if.saturated = out_sat_r;

endmodule

>>> hdl/dcmh_checker.sv
module dcmh_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_valid,
  input logic cfg_ready
);

  // words accepted but not yet delivered
  logic [1:0] pend_r, pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // the clearing pass keeps the input closed right after reset
  a_clr_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during counter clear");

  // no result without an outstanding word
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without accepted word");

  // at most two words in flight
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many words in flight");

  // config port never pushes back
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind dct_coeff_magnitude_histogram dcmh_checker u_dcmh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .cfg_valid (cfg_if.valid),
  .cfg_ready (cfg_if.ready)
);
